// ===== rtl/huffman_tree_decoder_defines.svh =====
// Assertion macros shared by the code tree decoder RTL.
`ifndef HUFFMAN_TREE_DECODER_DEFINES_SVH
`define HUFFMAN_TREE_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante.
`define HTD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("code tree decoder check failed");
// Check that cons holds in the cycle after ante.
`define HTD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("code tree decoder check failed");
`else
`define HTD_ASSERT_NOW(label, ante, cons)
`define HTD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/htd_pkg.sv =====
// Types, codes and constants of the code tree decoder.
package htd_pkg;

    localparam int SYMBOL_COUNT = 256;
    localparam int MAX_CODE_LEN = 32;
    localparam int NODE_DEPTH   = 512;

    localparam int SYM_W  = 8;
    localparam int LEN_W  = 6;
    localparam int NODE_W = $clog2(NODE_DEPTH);
    localparam int USED_W = $clog2(NODE_DEPTH + 1);
    localparam int SUM_W  = USED_W + 1;
    localparam int IDX_W  = (MAX_CODE_LEN > 1) ? $clog2(MAX_CODE_LEN) : 1;

    localparam logic [LEN_W-1:0]  LEN_ONE   = LEN_W'(1);
    localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(MAX_CODE_LEN);
    localparam logic [SYM_W:0]    SYM_LIMIT = (SYM_W + 1)'(SYMBOL_COUNT);
    localparam logic [USED_W-1:0] USED_ONE  = USED_W'(1);
    localparam logic [NODE_W-1:0] NODE_ONE  = NODE_W'(1);
    localparam logic [IDX_W-1:0]  IDX_ONE   = IDX_W'(1);
    localparam logic [SUM_W-1:0]  SUM_ONE   = SUM_W'(1);
    localparam logic [SUM_W-1:0]  SUM_LIMIT = SUM_W'(NODE_DEPTH);

    typedef enum logic [1:0] {
        FN_CLEAR  = 2'd0,
        FN_INSERT = 2'd1,
        FN_DECODE = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        ST_SYMBOL   = 3'd0,
        ST_INS_OK   = 3'd1,
        ST_CONFLICT = 3'd2,
        ST_MISSING  = 3'd3,
        ST_CLEARED  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEC_CUR,
        S_DEC_CHILD,
        S_INS_WALK,
        S_INS_LINK,
        S_INS_FILL,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [1:0]             has;
        logic [1:0][NODE_W-1:0] kid;
        logic [SYM_W-1:0]       sym;
    } node_t;

    typedef struct packed {
        logic [1:0]              func;
        logic [MAX_CODE_LEN-1:0] code_word;
        logic [LEN_W-1:0]        code_length;
        logic [SYM_W-1:0]        symbol_in;
        logic                    data_bit;
    } req_t;

    typedef struct packed {
        logic [SYM_W-1:0] symbol_out;
        logic [2:0]       status;
    } rsp_t;

    typedef struct packed {
        logic              we;
        logic [NODE_W-1:0] waddr;
        node_t             wdata;
        logic              re;
        logic [NODE_W-1:0] raddr;
    } store_req_t;

    typedef struct packed {
        node_t                   entry;
        logic [MAX_CODE_LEN-1:0] code;
        logic [IDX_W-1:0]        idx;
        logic                    use_data;
        logic                    data_bit;
    } step_req_t;

    typedef struct packed {
        logic              b;
        logic              has;
        logic [NODE_W-1:0] kid;
        logic              leaf;
        logic              last;
        logic [IDX_W-1:0]  idx_dn;
    } step_rsp_t;

endpackage

// ===== rtl/htd_node_store.sv =====
// Node store: one write port and one registered read port.
module htd_node_store (
    input  logic                clk,
    input  htd_pkg::store_req_t req,
    output htd_pkg::node_t      rdata
);

    htd_pkg::node_t mem [htd_pkg::NODE_DEPTH];
    htd_pkg::node_t rdata_reg;

    // Write one entry and read one entry per cycle
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/htd_step_unit.sv =====
// Shared tree step unit: bit select, branch lookup, leaf test, index count-down.
module htd_step_unit (
    input  htd_pkg::step_req_t req,
    output htd_pkg::step_rsp_t rsp
);

    logic b;

    // Pick the branch bit from the code word or from the decode bit
    assign b = req.use_data ? req.data_bit : req.code[req.idx];

    // Look up the branch and classify the node
    always_comb
    begin
        rsp.b      = b;
        rsp.has    = req.entry.has[b];
        rsp.kid    = req.entry.kid[b];
        rsp.leaf   = ~|req.entry.has;
        rsp.last   = (req.idx == '0);
        rsp.idx_dn = req.idx - htd_pkg::IDX_ONE;
    end

endmodule

// ===== rtl/huffman_tree_decoder.sv =====
// Code tree decoder: transaction channels, sequencer and tree state.
//
// Input transactions (req_valid/req_stall/req) carry one of three operations:
// clear the tree, insert a code of 1 to 32 bits, or decode one compressed bit.
// Result transactions (rsp_valid/rsp_stall/rsp) carry a symbol and a status.
// req_stall is high while an operation is in progress; one operation at a time.
// Steps per operation, from the accepting cycle up to the result register load:
//   clear: idle, emit.
//   decode, inner node reached: idle, current node, child; no result.
//   decode, leaf or missing branch: idle, current node, child (leaf only), emit.
//   insert: idle, a walk step per existing path node walked, link, a fill step
//   per new node, emit; a rejected insert ends earlier.
// Each tree step passes once through the shared step unit; walk and decode
// steps read a node, link and fill steps write one. A finished result sits in
// an output register; the next operation is accepted while it waits. If
// rsp_stall holds that register, a later result waits in the sequencer and
// req_stall stays high. After reset the tree holds only the root, the current
// node is the root and no result is pending. The store needs no clearing pass.
`include "huffman_tree_decoder_defines.svh"

module huffman_tree_decoder (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  htd_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output htd_pkg::rsp_t rsp
);

    // Control state
    htd_pkg::state_t                state_reg, state_next;
    logic [htd_pkg::NODE_W-1:0]     cur_node_reg, cur_node_next;
    logic [htd_pkg::USED_W-1:0]     nodes_used_reg, nodes_used_next;
    htd_pkg::node_t                 root_reg, root_next;
    logic                           fill_leaf_reg, fill_leaf_next;
    logic                           rsp_valid_reg, rsp_valid_next;

    // Operation payload
    logic [htd_pkg::MAX_CODE_LEN-1:0] code_reg, code_next;
    logic [htd_pkg::SYM_W-1:0]        sym_reg, sym_next;
    logic [htd_pkg::IDX_W-1:0]        idx_reg, idx_next;
    logic [htd_pkg::NODE_W-1:0]       node_reg, node_next;
    logic                             bit_reg, bit_next;
    htd_pkg::rsp_t                    res_reg, res_next;
    htd_pkg::rsp_t                    rsp_reg, rsp_next;

    htd_pkg::store_req_t        store_req;
    htd_pkg::node_t             store_rdata;
    htd_pkg::node_t             entry;
    htd_pkg::node_t             linked;
    htd_pkg::node_t             fresh;
    htd_pkg::step_req_t         step_req;
    htd_pkg::step_rsp_t         step_rsp;
    logic [htd_pkg::LEN_W-1:0]  len_m1;
    logic [htd_pkg::SUM_W-1:0]  cap_sum;
    logic                       cap_over;
    logic                       bad_insert;

    htd_node_store u_store (
        .clk   (clk),
        .req   (store_req),
        .rdata (store_rdata)
    );

    htd_step_unit u_step (
        .req (step_req),
        .rsp (step_rsp)
    );

    // The root lives in registers; other nodes come from the store
    assign entry = (node_reg == '0) ? root_reg : store_rdata;

    // Feed the shared step unit
    always_comb
    begin
        step_req.entry    = entry;
        step_req.code     = code_reg;
        step_req.idx      = idx_reg;
        step_req.use_data = (state_reg == htd_pkg::S_DEC_CUR) ||
                            (state_reg == htd_pkg::S_DEC_CHILD);
        step_req.data_bit = bit_reg;
    end

    // Check insert length, symbol and room in the store
    assign len_m1     = req.code_length - htd_pkg::LEN_ONE;
    assign bad_insert = (req.code_length == '0) || (req.code_length > htd_pkg::LEN_MAX) ||
                        ({1'b0, req.symbol_in} >= htd_pkg::SYM_LIMIT);
    assign cap_sum    = {1'b0, nodes_used_reg} +
                        {{(htd_pkg::SUM_W - htd_pkg::IDX_W){1'b0}}, idx_reg} +
                        htd_pkg::SUM_ONE;
    assign cap_over   = cap_sum > htd_pkg::SUM_LIMIT;

    // Attach the new branch to the node where the path ends
    always_comb
    begin
        linked                  = entry;
        linked.has[step_rsp.b]  = 1'b1;
        linked.kid[step_rsp.b]  = nodes_used_reg[htd_pkg::NODE_W-1:0];
    end

    // Build the next new node: a leaf or an inner node on the new path
    always_comb
    begin
        fresh = '0;
        if (fill_leaf_reg)
        begin
            fresh.sym = sym_reg;
        end
        else
        begin
            fresh.has[step_rsp.b] = 1'b1;
            fresh.kid[step_rsp.b] = nodes_used_reg[htd_pkg::NODE_W-1:0] + htd_pkg::NODE_ONE;
        end
    end

    // Sequencer: next state, store access and results
    always_comb
    begin
        state_next      = state_reg;
        cur_node_next   = cur_node_reg;
        nodes_used_next = nodes_used_reg;
        root_next       = root_reg;
        fill_leaf_next  = fill_leaf_reg;
        code_next       = code_reg;
        sym_next        = sym_reg;
        idx_next        = idx_reg;
        node_next       = node_reg;
        bit_next        = bit_reg;
        res_next        = res_reg;
        store_req       = '0;
        case (state_reg)
            htd_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    case (req.func)
                        htd_pkg::FN_CLEAR:
                        begin
                            root_next       = '0;
                            nodes_used_next = htd_pkg::USED_ONE;
                            cur_node_next   = '0;
                            res_next        = '{symbol_out: '0, status: htd_pkg::ST_CLEARED};
                            state_next      = htd_pkg::S_EMIT;
                        end
                        htd_pkg::FN_INSERT:
                        begin
                            if (bad_insert)
                            begin
                                res_next   = '{symbol_out: '0, status: htd_pkg::ST_CONFLICT};
                                state_next = htd_pkg::S_EMIT;
                            end
                            else
                            begin
                                code_next  = req.code_word;
                                sym_next   = req.symbol_in;
                                idx_next   = len_m1[htd_pkg::IDX_W-1:0];
                                node_next  = '0;
                                state_next = htd_pkg::S_INS_WALK;
                            end
                        end
                        htd_pkg::FN_DECODE:
                        begin
                            bit_next        = req.data_bit;
                            node_next       = cur_node_reg;
                            store_req.re    = 1'b1;
                            store_req.raddr = cur_node_reg;
                            state_next      = htd_pkg::S_DEC_CUR;
                        end
                        default:
                        begin
                            state_next = htd_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            htd_pkg::S_DEC_CUR:
            begin
                if (!step_rsp.has)
                begin
                    cur_node_next = '0;
                    res_next      = '{symbol_out: '0, status: htd_pkg::ST_MISSING};
                    state_next    = htd_pkg::S_EMIT;
                end
                else
                begin
                    node_next       = step_rsp.kid;
                    store_req.re    = 1'b1;
                    store_req.raddr = step_rsp.kid;
                    state_next      = htd_pkg::S_DEC_CHILD;
                end
            end
            htd_pkg::S_DEC_CHILD:
            begin
                if (step_rsp.leaf)
                begin
                    cur_node_next = '0;
                    res_next      = '{symbol_out: entry.sym, status: htd_pkg::ST_SYMBOL};
                    state_next    = htd_pkg::S_EMIT;
                end
                else
                begin
                    cur_node_next = node_reg;
                    state_next    = htd_pkg::S_IDLE;
                end
            end
            htd_pkg::S_INS_WALK:
            begin
                if ((node_reg != '0) && step_rsp.leaf)
                begin
                    // An existing code is a prefix of the new one
                    res_next   = '{symbol_out: '0, status: htd_pkg::ST_CONFLICT};
                    state_next = htd_pkg::S_EMIT;
                end
                else if (step_rsp.has)
                begin
                    if (step_rsp.last)
                    begin
                        res_next   = '{symbol_out: '0, status: htd_pkg::ST_CONFLICT};
                        state_next = htd_pkg::S_EMIT;
                    end
                    else
                    begin
                        node_next       = step_rsp.kid;
                        idx_next        = step_rsp.idx_dn;
                        store_req.re    = 1'b1;
                        store_req.raddr = step_rsp.kid;
                    end
                end
                else if (cap_over)
                begin
                    res_next   = '{symbol_out: '0, status: htd_pkg::ST_CONFLICT};
                    state_next = htd_pkg::S_EMIT;
                end
                else
                begin
                    state_next = htd_pkg::S_INS_LINK;
                end
            end
            htd_pkg::S_INS_LINK:
            begin
                if (node_reg == '0)
                begin
                    root_next = linked;
                end
                else
                begin
                    store_req.we    = 1'b1;
                    store_req.waddr = node_reg;
                    store_req.wdata = linked;
                end
                fill_leaf_next = step_rsp.last;
                idx_next       = step_rsp.idx_dn;
                state_next     = htd_pkg::S_INS_FILL;
            end
            htd_pkg::S_INS_FILL:
            begin
                store_req.we    = 1'b1;
                store_req.waddr = nodes_used_reg[htd_pkg::NODE_W-1:0];
                store_req.wdata = fresh;
                nodes_used_next = nodes_used_reg + htd_pkg::USED_ONE;
                if (fill_leaf_reg)
                begin
                    fill_leaf_next = 1'b0;
                    res_next       = '{symbol_out: '0, status: htd_pkg::ST_INS_OK};
                    state_next     = htd_pkg::S_EMIT;
                end
                else
                begin
                    fill_leaf_next = step_rsp.last;
                    idx_next       = step_rsp.idx_dn;
                end
            end
            htd_pkg::S_EMIT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    state_next = htd_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = htd_pkg::S_IDLE;
            end
        endcase
    end

    // Load the output register from a finished result, drop it once taken
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        if ((state_reg == htd_pkg::S_EMIT) && (!rsp_valid_reg || !rsp_stall))
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = res_reg;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= htd_pkg::S_IDLE;
            cur_node_reg   <= '0;
            nodes_used_reg <= htd_pkg::USED_ONE;
            root_reg       <= '0;
            fill_leaf_reg  <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_node_reg   <= cur_node_next;
            nodes_used_reg <= nodes_used_next;
            root_reg       <= root_next;
            fill_leaf_reg  <= fill_leaf_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Hold operation payload
    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        sym_reg  <= sym_next;
        idx_reg  <= idx_next;
        node_reg <= node_next;
        bit_reg  <= bit_next;
        res_reg  <= res_next;
        rsp_reg  <= rsp_next;
    end

    assign req_stall = (state_reg != htd_pkg::S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Checks on the sequencer and the tree state
    `HTD_ASSERT_NOW(a_used_range, 1'b1, (nodes_used_reg != '0) && ({1'b0, nodes_used_reg} <= htd_pkg::SUM_LIMIT))
    `HTD_ASSERT_NEXT(a_clear_resets, req_valid && !req_stall && (req.func == htd_pkg::FN_CLEAR), (nodes_used_reg == htd_pkg::USED_ONE) && (cur_node_reg == '0) && (root_reg.has == '0))
    `HTD_ASSERT_NOW(a_fill_in_range, state_reg == htd_pkg::S_INS_FILL, {1'b0, nodes_used_reg} < htd_pkg::SUM_LIMIT)
    `HTD_ASSERT_NEXT(a_emit_waits, (state_reg == htd_pkg::S_EMIT) && rsp_valid_reg && rsp_stall, state_reg == htd_pkg::S_EMIT)
    `HTD_ASSERT_NOW(a_no_root_write, store_req.we, store_req.waddr != '0)

endmodule
